@@ hw/rtl/lfdc_pkg.sv @@
// Package for the line follower drive controller.
// Holds the command and turn codes, register indexes and the shared word types.
// No dependencies; every other file imports it.
package lfdc_pkg;

   typedef enum logic [1:0] {
      CMD_MS     = 2'd0,
      CMD_BUTTON = 2'd1,
      CMD_CTRL   = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      TURN_STRAIGHT = 2'd0,
      TURN_LEFT     = 2'd1,
      TURN_RIGHT    = 2'd2
   } turn_type;

   localparam int unsigned SPEED_W = 10;
   localparam int unsigned DRIVE_W = 11;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned INDEX_W = 3;

   localparam logic [INDEX_W-1:0] REG_FAST_SPEED       = 3'd0;
   localparam logic [INDEX_W-1:0] REG_BASE_SPEED       = 3'd1;
   localparam logic [INDEX_W-1:0] REG_MIN_SPEED        = 3'd2;
   localparam logic [INDEX_W-1:0] REG_DEBOUNCE_MS      = 3'd3;
   localparam logic [INDEX_W-1:0] REG_FINISH_CROSSINGS = 3'd4;
   localparam logic [INDEX_W-1:0] REG_BLINK_FAST_MS    = 3'd5;
   localparam logic [INDEX_W-1:0] REG_BLINK_SLOW_MS    = 3'd6;

   typedef struct packed {
      logic [SPEED_W-1:0] fast_speed;
      logic [SPEED_W-1:0] base_speed;
      logic [SPEED_W-1:0] min_speed;
      logic [SPEED_W-1:0] debounce_ms;
      logic [COUNT_W-1:0] finish_crossings;
      logic [SPEED_W-1:0] blink_fast_ms;
      logic [SPEED_W-1:0] blink_slow_ms;
   } cfg_type;

   typedef struct packed {
      cmd_type command;
      logic    button_level;
      logic    sense_left;
      logic    sense_middle;
      logic    sense_right;
   } item_type;

   typedef struct packed {
      logic [COUNT_W-1:0]        crossings_seen;
      logic                      running_now;
      logic                      led_on;
      logic signed [DRIVE_W-1:0] right_drive;
      logic signed [DRIVE_W-1:0] left_drive;
   } result_type;

endpackage

@@ hw/rtl/lfdc_csr.sv @@
// Configuration register bank of the line follower drive controller.
// Takes index and data words from the configuration channel; depends on lfdc_pkg.
module lfdc_csr
   import lfdc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [INDEX_W-1:0]  csr_index,
   input  logic [SPEED_W-1:0]  csr_data,
   output cfg_type             cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_FAST_SPEED:       cfg_in.fast_speed       = csr_data;
            REG_BASE_SPEED:       cfg_in.base_speed       = csr_data;
            REG_MIN_SPEED:        cfg_in.min_speed        = csr_data;
            REG_DEBOUNCE_MS:      cfg_in.debounce_ms      = csr_data;
            REG_FINISH_CROSSINGS: cfg_in.finish_crossings = csr_data[COUNT_W-1:0];
            REG_BLINK_FAST_MS:    cfg_in.blink_fast_ms    = csr_data;
            REG_BLINK_SLOW_MS:    cfg_in.blink_slow_ms    = csr_data;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_speed       <= 10'd550;
         cfg_ff.base_speed       <= 10'd450;
         cfg_ff.min_speed        <= 10'd350;
         cfg_ff.debounce_ms      <= 10'd50;
         cfg_ff.finish_crossings <= 4'd3;
         cfg_ff.blink_fast_ms    <= 10'd100;
         cfg_ff.blink_slow_ms    <= 10'd500;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ hw/rtl/lfdc_core.sv @@
// Controller state and its combinational update for one input word.
// Keeps tick, blink, button, crossing and steering state; depends on lfdc_pkg.
module lfdc_core
   import lfdc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   logic [31:0]               tick_ff, tick_in, press_ff, press_in, held;
   logic [SPEED_W-1:0]        blink_ff, blink_in, blink_inc, interval;
   logic                      led_ff, led_in, run_ff, run_in, oc_ff, oc_in;
   turn_type                  turn_ff, turn_in;
   logic [COUNT_W-1:0]        cnt_ff, cnt_in, cnt_hit;
   logic signed [DRIVE_W-1:0] left_ff, left_in, right_ff, right_in;
   logic signed [DRIVE_W-1:0] fs, bs, ms;
   logic                      sl, sm, sr;

   assign sl = item.sense_left;
   assign sm = item.sense_middle;
   assign sr = item.sense_right;
   assign fs = $signed({1'b0, cfg.fast_speed});
   assign bs = $signed({1'b0, cfg.base_speed});
   assign ms = $signed({1'b0, cfg.min_speed});

   assign blink_inc = blink_ff + 10'd1;
   assign interval  = run_ff ? cfg.blink_fast_ms : cfg.blink_slow_ms;
   assign held      = tick_ff - press_ff;
   assign cnt_hit   = (!oc_ff && (cnt_ff != 4'hF)) ? cnt_ff + 4'd1 : cnt_ff;

   always_comb begin
      tick_in  = tick_ff;
      press_in = press_ff;
      blink_in = blink_ff;
      led_in   = led_ff;
      run_in   = run_ff;
      oc_in    = oc_ff;
      turn_in  = turn_ff;
      cnt_in   = cnt_ff;
      left_in  = left_ff;
      right_in = right_ff;
      unique case (item.command)
         CMD_MS: begin
            tick_in = tick_ff + 32'd1;
            if (blink_inc >= interval) begin
               led_in   = !led_ff;
               blink_in = '0;
            end else begin
               blink_in = blink_inc;
            end
         end
         CMD_BUTTON: begin
            if (!item.button_level) begin
               press_in = tick_ff;
            end else if (held >= {22'd0, cfg.debounce_ms}) begin
               run_in = !run_ff;
               if (!run_ff) begin
                  cnt_in = '0;
                  oc_in  = 1'b0;
               end
            end
         end
         CMD_CTRL: begin
            if (!run_ff) begin
               left_in  = '0;
               right_in = '0;
            end else if (sl && sr) begin
               oc_in  = 1'b1;
               cnt_in = cnt_hit;
               if (cnt_hit >= cfg.finish_crossings) begin
                  left_in  = '0;
                  right_in = '0;
                  run_in   = 1'b0;
               end else begin
                  turn_in  = TURN_STRAIGHT;
                  left_in  = bs;
                  right_in = bs;
               end
            end else begin
               if (!sl && !sr) begin
                  oc_in = 1'b0;
               end
               priority if (!sl && sm && !sr) begin
                  turn_in  = TURN_STRAIGHT;
                  left_in  = bs;
                  right_in = bs;
               end else if (sl && sm) begin
                  turn_in  = TURN_LEFT;
                  left_in  = ms;
                  right_in = fs;
               end else if (sm && sr) begin
                  turn_in  = TURN_RIGHT;
                  left_in  = fs;
                  right_in = ms;
               end else if (sl) begin
                  turn_in  = TURN_LEFT;
                  left_in  = '0;
                  right_in = fs;
               end else if (sr) begin
                  turn_in  = TURN_RIGHT;
                  left_in  = fs;
                  right_in = '0;
               end else begin
                  unique case (turn_ff)
                     TURN_LEFT: begin
                        left_in  = -ms;
                        right_in = ms;
                     end
                     TURN_RIGHT: begin
                        left_in  = ms;
                        right_in = -ms;
                     end
                     default: begin
                        left_in  = '0;
                        right_in = '0;
                     end
                  endcase
               end
            end
         end
         default: begin
            tick_in = tick_ff;
         end
      endcase
   end

   assign result.crossings_seen = cnt_in;
   assign result.running_now    = run_in;
   assign result.led_on         = led_in;
   assign result.right_drive    = right_in;
   assign result.left_drive     = left_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff  <= '0;
         press_ff <= '0;
         blink_ff <= '0;
         led_ff   <= 1'b0;
         run_ff   <= 1'b0;
         oc_ff    <= 1'b0;
         turn_ff  <= TURN_STRAIGHT;
         cnt_ff   <= '0;
         left_ff  <= '0;
         right_ff <= '0;
      end else if (step) begin
         tick_ff  <= tick_in;
         press_ff <= press_in;
         blink_ff <= blink_in;
         led_ff   <= led_in;
         run_ff   <= run_in;
         oc_ff    <= oc_in;
         turn_ff  <= turn_in;
         cnt_ff   <= cnt_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

@@ hw/rtl/line_follower_drive_controller_top.sv @@
// Top level of the line follower drive controller: input and result registers.
// Instantiates lfdc_csr and lfdc_core; depends on lfdc_pkg.
//
//   channel | direction | handshake          | word
//   req     | in        | req_tvalid/tready  | tuser command, tdata button and sensors
//   rsp     | out       | rsp_tvalid/tready  | tdata drives, LED, running, crossings
//   csr     | in        | csr_valid/ready    | csr_index, csr_data
//
// Each word is latched in the input register, processed combinationally and its
// result latched in the result register; one word per cycle is sustained while
// rsp_tready is high. A stalled result register holds
// its word; the input register still takes one more word behind it.
// Reset empties both registers and clears all controller state; csr_ready is always high.
module line_follower_drive_controller_top
   import lfdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,  // button_level, sense_left, sense_middle, sense_right
   input  logic [1:0]         req_tuser,  // command
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,  // left_drive, right_drive, led_on, running_now,
                                          // crossings_seen
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [INDEX_W-1:0] csr_index,
   input  logic [SPEED_W-1:0] csr_data
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   result_type result, rsp_ff;
   logic       in_valid_ff, in_valid_in, out_valid_ff, out_valid_in, advance;

   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   assign item_in.command      = cmd_type'(req_tuser);
   assign item_in.button_level = req_tdata[0];
   assign item_in.sense_left   = req_tdata[1];
   assign item_in.sense_middle = req_tdata[2];
   assign item_in.sense_right  = req_tdata[3];

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_ff.crossings_seen, rsp_ff.running_now, rsp_ff.led_on,
                        rsp_ff.right_drive, rsp_ff.left_drive};

   lfdc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lfdc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

endmodule

@@ hw/rtl/lfdc_checker.sv @@
// Port-level checker for the line follower drive controller, bound to the top level.
// Sees only the top level's ports; depends on lfdc_pkg.
module lfdc_checker
   import lfdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // A result word is empty right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word valid right after reset");

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   // With the result register empty the input side never stalls.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // Wheel speeds never reach the most negative code.
   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[10:0] != 11'h400) && (rsp_tdata[21:11] != 11'h400))
      else $error("wheel speed out of range");

endmodule

bind line_follower_drive_controller_top lfdc_checker u_lfdc_checker (.*);
